/* design/dspad_pkg.sv */
`timescale 1ns / 1ps

package dspad_pkg;

  // Item kinds carried in the low bits of in_tuser.
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_EVENT = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Register selector codes; the remaining codes select nothing.
  localparam logic [2:0] SEL_CTRL   = 3'd0;
  localparam logic [2:0] SEL_ADDR_H = 3'd1;
  localparam logic [2:0] SEL_ADDR_L = 3'd2;
  localparam logic [2:0] SEL_LENGTH = 3'd3;
  localparam logic [2:0] SEL_COUNT  = 3'd4;

  // Stream block geometry: 32-byte blocks, so addresses keep 5 zero bits.
  localparam int BlockBytes = 32;
  localparam int BlkShift   = $clog2(BlockBytes);
  localparam int AddrW      = 26;
  localparam int BlkAddrW   = AddrW - BlkShift;
  localparam int AddrHW     = 10;
  localparam int AddrLW     = 16 - BlkShift;
  localparam int CountW     = 15;

  // Interrupt source positions within the mask and pending fields.
  localparam int IntAudio = 0;
  localparam int IntAram  = 1;
  localparam int IntDsp   = 2;

  // Accepted input item.
  typedef struct packed {
    logic [15:0] wdata;
    logic [2:0]  reg_sel;
    op_t         op;
  } item_t;

  // One result item, in tdata order from the highest bit down.
  typedef struct packed {
    logic [2:0]       dsp_controls;
    logic             stream_enable;
    logic [AddrW-1:0] fetch_addr;
    logic             fetch_valid;
    logic             irq_line;
    logic [15:0]      rdata;
  } result_t;

endpackage

/* design/dsp_interface_audio_dma_regs.sv */
`timescale 1ns / 1ps
// Each accepted item waits in the input register until the output register is free
// or draining; its result item then waits in the output register until taken.
// Throughput: one item per cycle unless the receiver holds out_tready low.
// Reset (rst_n low, synchronous): all registers, the pending and mask bits, the
// stream counter and address, and both stages' valid flags are cleared.

module dsp_interface_audio_dma_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] wdata
  input  logic [4:0]  in_tuser,   // [1:0] op, [4:2] reg_sel
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] rdata, [16] irq_line, [17] fetch_valid, [43:18] fetch_addr,
  // [44] stream_enable, [47:45] dsp_controls
  output logic [47:0] out_tdata
);
  import dspad_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    adv;
  result_t res;
  logic    out_valid_r;
  result_t out_data_r;

  assign in_item.op      = op_t'(in_tuser[1:0]);
  assign in_item.reg_sel = in_tuser[4:2];
  assign in_item.wdata   = in_tdata;

  // The held item is processed when the output register is free or draining.
  assign adv = item_valid && (!out_valid_r || out_tready);

  dspad_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  dspad_regs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (item),
    .res   (res)
  );

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/dspad_in_reg.sv */
`timescale 1ns / 1ps

module dspad_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  dspad_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output dspad_pkg::item_t item
);
  import dspad_pkg::*;

  logic  valid_r;
  item_t item_r;

  // A new item enters whenever the register is empty or is emptied this cycle.
  assign in_tready  = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  // Item payload.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

endmodule

/* design/dspad_regs_core.sv */
`timescale 1ns / 1ps

module dspad_regs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  dspad_pkg::item_t  item,
  output dspad_pkg::result_t res
);
  import dspad_pkg::*;

  logic [2:0]          masks_r, masks_nxt;
  logic [2:0]          pend_r, pend_nxt;
  logic                rmode_r, rmode_nxt;
  logic [2:0]          ctl_r, ctl_nxt;
  logic [AddrHW-1:0]   addr_h_r, addr_h_nxt;
  logic [AddrLW-1:0]   addr_l_r, addr_l_nxt;
  logic [15:0]         length_r, length_nxt;
  logic [CountW-1:0]   count_r, count_nxt;
  logic [BlkAddrW-1:0] cur_r, cur_nxt;
  logic                irq_r, irq_nxt;
  logic [BlkAddrW-1:0] start_blk;
  logic [15:0]         ctrl_rd;
  logic [15:0]         rdata;
  logic                fvalid;
  logic [2:0]          pend_clr;

  // Start address in block units; the low address register keeps only
  // its block-aligned bits.
  assign start_blk = {addr_h_r, addr_l_r};

  // Control register read image.
  always_comb begin
    ctrl_rd      = '0;
    ctrl_rd[2:0] = ctl_r;
    ctrl_rd[3]   = pend_r[IntAudio];
    ctrl_rd[4]   = masks_r[IntAudio];
    ctrl_rd[5]   = pend_r[IntAram];
    ctrl_rd[6]   = masks_r[IntAram];
    ctrl_rd[7]   = pend_r[IntDsp];
    ctrl_rd[8]   = masks_r[IntDsp];
    ctrl_rd[11]  = rmode_r;
  end

  // Next state and result for the item in the input register.
  always_comb begin
    masks_nxt  = masks_r;
    pend_nxt   = pend_r;
    rmode_nxt  = rmode_r;
    ctl_nxt    = ctl_r;
    addr_h_nxt = addr_h_r;
    addr_l_nxt = addr_l_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    irq_nxt    = irq_r;
    rdata      = '0;
    fvalid     = 1'b0;
    pend_clr   = {item.wdata[7], item.wdata[5], item.wdata[3]};

    unique case (item.op)
      OP_READ: begin
        unique case (item.reg_sel)
          SEL_CTRL:   rdata = ctrl_rd;
          SEL_ADDR_H: rdata = {{(16 - AddrHW){1'b0}}, addr_h_r};
          SEL_ADDR_L: rdata = {addr_l_r, {BlkShift{1'b0}}};
          SEL_LENGTH: rdata = length_r;
          SEL_COUNT:  rdata = {1'b0, count_r};
          default:    rdata = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (item.reg_sel)
          SEL_CTRL: begin
            masks_nxt = {item.wdata[8], item.wdata[6], item.wdata[4]};
            pend_nxt  = pend_r & ~pend_clr;
            if (pend_nxt == 3'b000) begin
              irq_nxt = 1'b0;
            end
            rmode_nxt = item.wdata[11];
            ctl_nxt   = item.wdata[2:0];
          end
          SEL_ADDR_H: addr_h_nxt = item.wdata[AddrHW-1:0];
          SEL_ADDR_L: addr_l_nxt = item.wdata[15:BlkShift];
          SEL_LENGTH: begin
            length_nxt = item.wdata;
            if (item.wdata[15]) begin
              count_nxt = item.wdata[CountW-1:0];
              cur_nxt   = start_blk;
            end else begin
              count_nxt = '0;
            end
          end
          default: ;
        endcase
      end
      OP_EVENT: begin
        pend_nxt[IntDsp] = 1'b1;
        if (masks_r[IntDsp]) begin
          irq_nxt = 1'b1;
        end
      end
      OP_TICK: begin
        if (length_r[15]) begin
          if (count_r == '0) begin
            // End of the run: reload and flag the audio interrupt.
            cur_nxt            = start_blk;
            count_nxt          = length_r[CountW-1:0];
            pend_nxt[IntAudio] = 1'b1;
            if (masks_r[IntAudio]) begin
              irq_nxt = 1'b1;
            end
          end else begin
            fvalid    = 1'b1;
            cur_nxt   = cur_r + 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // irq_line, enable and controls show the state after the item.
  always_comb begin
    res.rdata         = rdata;
    res.irq_line      = irq_nxt;
    res.fetch_valid   = fvalid;
    res.fetch_addr    = fvalid ? {cur_r, {BlkShift{1'b0}}} : '0;
    res.stream_enable = length_nxt[15];
    res.dsp_controls  = ctl_nxt;
  end

  // Register file and stream state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r  <= '0;
      pend_r   <= '0;
      rmode_r  <= 1'b0;
      ctl_r    <= '0;
      addr_h_r <= '0;
      addr_l_r <= '0;
      length_r <= '0;
      count_r  <= '0;
      cur_r    <= '0;
      irq_r    <= 1'b0;
    end else if (adv) begin
      masks_r  <= masks_nxt;
      pend_r   <= pend_nxt;
      rmode_r  <= rmode_nxt;
      ctl_r    <= ctl_nxt;
      addr_h_r <= addr_h_nxt;
      addr_l_r <= addr_l_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      cur_r    <= cur_nxt;
      irq_r    <= irq_nxt;
    end
  end

`ifndef ASSERT_OFF
  // The interrupt line is never high with nothing pending.
  a_irq_needs_pending: assert property (@(posedge clk) disable iff (!rst_n)
    irq_r |-> (pend_r != 3'b000))
    else $error("interrupt line high with no pending bit");

  // Fetches come only from enabled ticks with blocks left.
  a_fetch_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    res.fetch_valid |-> (item.op == OP_TICK) && length_r[15] && (count_r != '0))
    else $error("fetch outside an enabled tick");

  // A reload tick restores the count from the length register.
  a_reload_count: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item.op == OP_TICK) && length_r[15] && (count_r == '0))
      |=> (count_r == $past(length_r[CountW-1:0])) && pend_r[IntAudio])
    else $error("reload tick did not restore count");

  // Clearing the enable bit stops the stream.
  a_disable_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (item.op == OP_WRITE) && (item.reg_sel == SEL_LENGTH) && !item.wdata[15])
      |=> (count_r == '0) && !length_r[15])
    else $error("length write without enable left a count");
`endif

endmodule

/* tb/dsp_interface_audio_dma_regs_tb.sv */
`timescale 1ns / 1ps

import dspad_pkg::*;

// Tracks the register and stream state of the block, works out the result item
// due for every accepted input item, and checks result items in order.
class dsp_regs_tracker;
  bit [2:0]  masks;
  bit [2:0]  pending;
  bit        rst_mode;
  bit [2:0]  ctrl;
  bit [9:0]  addr_hi;
  bit [15:0] addr_lo;
  bit [15:0] len_reg;
  bit [14:0] blk_count;
  bit [25:0] cur_addr;
  bit        irq;
  result_t   due_results[$];
  int        mismatches;
  int        checked;

  function new();
    masks = '0;
    pending = '0;
    rst_mode = 1'b0;
    ctrl = '0;
    addr_hi = '0;
    addr_lo = '0;
    len_reg = '0;
    blk_count = '0;
    cur_addr = '0;
    irq = 1'b0;
    mismatches = 0;
    checked = 0;
  endfunction

  // Prints one line per mismatch and keeps the count.
  function void flag(string msg);
    $display("MISMATCH at result %0d: %s", checked, msg);
    mismatches++;
  endfunction

  function bit [15:0] read_reg(bit [2:0] sel);
    case (sel)
      SEL_CTRL:   return {4'b0, rst_mode, 2'b0, masks[IntDsp], pending[IntDsp],
                          masks[IntAram], pending[IntAram], masks[IntAudio],
                          pending[IntAudio], ctrl};
      SEL_ADDR_H: return {6'b0, addr_hi};
      SEL_ADDR_L: return addr_lo;
      SEL_LENGTH: return len_reg;
      SEL_COUNT:  return {1'b0, blk_count};
      default:    return 16'h0000;
    endcase
  endfunction

  function void write_reg(bit [2:0] sel, bit [15:0] d);
    case (sel)
      SEL_CTRL: begin
        // Pending bits are write-one-to-clear; the line only drops when none is left.
        masks = {d[8], d[6], d[4]};
        pending = pending & ~{d[7], d[5], d[3]};
        if (pending == 3'b000) irq = 1'b0;
        rst_mode = d[11];
        ctrl = d[2:0];
      end
      SEL_ADDR_H: addr_hi = d[9:0];
      SEL_ADDR_L: addr_lo = {d[15:5], 5'b0};
      SEL_LENGTH: begin
        len_reg = d;
        if (d[15]) begin
          blk_count = d[14:0];
          cur_addr = {addr_hi, addr_lo};
        end else begin
          blk_count = '0;
        end
      end
      default: ;
    endcase
  endfunction

  // Notes an accepted input item and queues the result item it causes.
  function void take_item(item_t it);
    result_t want;
    want = '0;
    case (it.op)
      OP_READ:  want.rdata = read_reg(it.reg_sel);
      OP_WRITE: write_reg(it.reg_sel, it.wdata);
      OP_EVENT: begin
        pending[IntDsp] = 1'b1;
        if (masks[IntDsp]) irq = 1'b1;
      end
      default: begin
        // Block tick: fetch while blocks remain, otherwise reload and flag audio.
        if (len_reg[15]) begin
          if (blk_count == '0) begin
            cur_addr = {addr_hi, addr_lo};
            blk_count = len_reg[14:0];
            pending[IntAudio] = 1'b1;
            if (masks[IntAudio]) irq = 1'b1;
          end else begin
            want.fetch_valid = 1'b1;
            want.fetch_addr = cur_addr;
            cur_addr = cur_addr + 26'd32;
            blk_count = blk_count - 15'd1;
          end
        end
      end
    endcase
    want.irq_line = irq;
    want.stream_enable = len_reg[15];
    want.dsp_controls = ctrl;
    due_results.push_back(want);
  endfunction

  // Compares a result item field by field with the oldest one due.
  function void check_result(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      flag("result item arrived with nothing due");
      return;
    end
    want = due_results.pop_front();
    if (got.rdata !== want.rdata)
      flag($sformatf("rdata %h, expected %h", got.rdata, want.rdata));
    if (got.irq_line !== want.irq_line)
      flag($sformatf("irq_line %b, expected %b", got.irq_line, want.irq_line));
    if (got.fetch_valid !== want.fetch_valid)
      flag($sformatf("fetch_valid %b, expected %b", got.fetch_valid, want.fetch_valid));
    if (got.fetch_addr !== want.fetch_addr)
      flag($sformatf("fetch_addr %h, expected %h", got.fetch_addr, want.fetch_addr));
    if (got.stream_enable !== want.stream_enable)
      flag($sformatf("stream_enable %b, expected %b", got.stream_enable,
                     want.stream_enable));
    if (got.dsp_controls !== want.dsp_controls)
      flag($sformatf("dsp_controls %b, expected %b", got.dsp_controls,
                     want.dsp_controls));
    checked++;
  endfunction

  function void finish_check();
    if (due_results.size() != 0)
      flag($sformatf("%0d result items never arrived", due_results.size()));
  endfunction
endclass

module dsp_interface_audio_dma_regs_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [4:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  dsp_regs_tracker tracker;

  dsp_interface_audio_dma_regs dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Run limit, far above the slowest correct run.
  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

  // Watches both channels at each rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) tracker.take_item(item_t'({in_tdata, in_tuser}));
      if (out_tvalid && out_tready) tracker.check_result(result_t'(out_tdata));
    end
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_len;
    forever begin
      if (hold_request != 0) begin
        hold_len = hold_request;
        hold_request = 0;
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
      @(posedge clk);
    end
  end

  // Offers one item and returns at the edge where it is accepted.
  task automatic send_item(item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= it.wdata;
    in_tuser <= {it.reg_sel, it.op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_op(op_t op, logic [2:0] sel, logic [15:0] d);
    item_t it;
    it.op = op;
    it.reg_sel = sel;
    it.wdata = d;
    send_item(it);
  endtask

  // Weighted toward ticks and length writes with short block counts, so that the stream
  // runs through fetches, reloads and interrupts; the rest is random noise.
  function automatic item_t random_item();
    item_t it;
    int r;
    int s;
    int k;
    r = $urandom_range(99);
    s = $urandom_range(99);
    k = $urandom_range(9);
    it.reg_sel = 3'($urandom_range(7));
    it.wdata = 16'($urandom);
    if (r < 40) begin
      it.op = OP_TICK;
    end else if (r < 50) begin
      it.op = OP_EVENT;
    end else if (r < 70) begin
      it.op = OP_READ;
    end else begin
      it.op = OP_WRITE;
      if (s < 30) it.reg_sel = SEL_CTRL;
      else if (s < 42) it.reg_sel = SEL_ADDR_H;
      else if (s < 54) it.reg_sel = SEL_ADDR_L;
      else if (s < 85) it.reg_sel = SEL_LENGTH;
      else it.reg_sel = 3'($urandom_range(4, 7));
      if (it.reg_sel == SEL_LENGTH) begin
        if (k < 7) it.wdata = {1'b1, 15'($urandom_range(6))};
        else if (k == 8) it.wdata[15] = 1'b0;
      end
    end
    return it;
  endfunction

  task automatic send_random(int n);
    repeat (n) send_item(random_item());
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every register, the interrupt rules and the stream cases.
    send_op(OP_READ, SEL_CTRL, 16'hFFFF);
    send_op(OP_WRITE, SEL_CTRL, 16'hFFFF);
    send_op(OP_READ, SEL_CTRL, 16'h0000);
    send_op(OP_EVENT, 3'd7, 16'hFFFF);
    send_op(OP_READ, SEL_CTRL, 16'h0000);
    // Masks cleared with the DSP bit still pending: the line stays up.
    send_op(OP_WRITE, SEL_CTRL, 16'h0000);
    send_op(OP_WRITE, SEL_CTRL, 16'h0190);
    send_op(OP_WRITE, SEL_ADDR_H, 16'hFFFF);
    send_op(OP_WRITE, SEL_ADDR_L, 16'hFFFF);
    send_op(OP_WRITE, SEL_LENGTH, 16'h8002);
    // Two fetches, the second wrapping the address, then a reload.
    send_op(OP_TICK, SEL_CTRL, 16'h0000);
    send_op(OP_TICK, 3'd7, 16'hFFFF);
    send_op(OP_TICK, SEL_CTRL, 16'h0000);
    // The block count register is read-only; unused selectors read zero.
    send_op(OP_WRITE, SEL_COUNT, 16'hFFFF);
    send_op(OP_READ, SEL_COUNT, 16'hFFFF);
    send_op(OP_WRITE, 3'd7, 16'hFFFF);
    send_op(OP_READ, 3'd5, 16'h0000);
    send_op(OP_READ, 3'd7, 16'h0000);
    // Enabled with a zero count: the next tick reloads at once.
    send_op(OP_WRITE, SEL_LENGTH, 16'h8000);
    send_op(OP_TICK, SEL_CTRL, 16'h0000);
    send_op(OP_WRITE, SEL_CTRL, 16'h0028);
    send_op(OP_WRITE, SEL_LENGTH, 16'h7FFF);
    send_op(OP_TICK, SEL_CTRL, 16'h0000);
    send_op(OP_READ, SEL_LENGTH, 16'h0000);
    send_op(OP_READ, SEL_ADDR_H, 16'h0000);
    send_op(OP_READ, SEL_ADDR_L, 16'h0000);
    // DSP event with its mask clear must not raise the line.
    send_op(OP_EVENT, SEL_CTRL, 16'h0000);
    send_op(OP_READ, SEL_CTRL, 16'h0000);

    // Random part in three idling phases.
    send_idle_pct = 8;
    recv_idle_pct = 52;
    send_random(290);
    send_idle_pct = 52;
    recv_idle_pct = 8;
    send_random(290);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(230);

    // Long receiver hold-off while items keep coming, to back up the input.
    hold_request = 200;
    send_random(60);

    in_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    tracker.finish_check();
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
